@@ rtl/core/cfb_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the clipped rectangle-fill framebuffer.
package cfb_pkg;

	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 512;
	localparam int COLOUR_BITS  = 16;
	localparam int RESET_WIDTH  = 240;
	localparam int RESET_HEIGHT = 320;

	// Bounds hold values up to and including the maximum size.
	localparam int XB_W   = $clog2(MAX_WIDTH + 1);
	localparam int YB_W   = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int KIND_W       = 3;
	localparam int COORD_W      = 16;
	localparam int EDGE_W       = COORD_W + 2;
	localparam int SW_REG_W     = 9;
	localparam int SH_REG_W     = 10;
	localparam int CFG_W        = 10;
	localparam int COUNT_W      = 18;
	localparam int OUT_COLOUR_W = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_PIXEL      = 3'd0,
		KIND_FILL       = 3'd1,
		KIND_NARROW     = 3'd2,
		KIND_RESET_CLIP = 3'd3,
		KIND_READ       = 3'd4
	} kind_t;

	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BOUNDS,
		ST_BASE,
		ST_FILL,
		ST_READ,
		ST_RDOUT
	} seq_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] rect_w;
		logic signed [COORD_W-1:0] rect_h;
		logic [COLOUR_BITS-1:0]    colour;
	} item_t;

	typedef struct packed {
		logic            empty;
		logic [XB_W-1:0] x0;
		logic [XB_W-1:0] x1;
		logic [YB_W-1:0] y0;
		logic [YB_W-1:0] y1;
	} bounds_t;

	typedef struct packed {
		logic                   we;
		logic                   re;
		logic [ADDR_W-1:0]      addr;
		logic [COLOUR_BITS-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic                    done;
		logic [OUT_COLOUR_W-1:0] read_colour;
		logic [COUNT_W-1:0]      pixels_written;
	} result_t;

	function automatic logic [XB_W-1:0] clamp_width(input logic [SW_REG_W-1:0] v);
		logic [XB_W-1:0] r;
		if (v == '0) begin
			r = XB_W'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = XB_W'(MAX_WIDTH);
		end else begin
			r = XB_W'(v);
		end
		return r;
	endfunction

	function automatic logic [YB_W-1:0] clamp_height(input logic [SH_REG_W-1:0] v);
		logic [YB_W-1:0] r;
		if (v == '0) begin
			r = YB_W'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = YB_W'(MAX_HEIGHT);
		end else begin
			r = YB_W'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/clipped_rect_fill_framebuffer_top.sv @@
`timescale 1ns / 1ps
// Top level of the clipped rectangle-fill framebuffer drawing engine.
// Busy covers only the bounds state for a clip or unused request, and bounds and base for a
// pixel, fill or read that touches nothing; writes add the fill walk, reads the read states.
// Done pulses for exactly one cycle, in the same cycle as busy falls; the next request may be taken then.
// Fills run at one pixel per cycle through the single write port of the frame store.
// After reset, busy stays high while a clearing pass zeroes all 131072 entries, one per cycle.
module clipped_rect_fill_framebuffer_top import cfb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] rect_w,
	input  logic signed [COORD_W-1:0] rect_h,
	input  logic [OUT_COLOUR_W-1:0]   colour,
	output logic                      done,
	output logic [OUT_COLOUR_W-1:0]   read_colour,
	output logic [COUNT_W-1:0]        pixels_written,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	item_t                  item_in;
	item_t                  item_q;
	bounds_t                bnd;
	logic                   bnd_en;
	logic [XB_W-1:0]        screen_w;
	mem_req_t               mem_req;
	logic [COLOUR_BITS-1:0] rd_data;
	result_t                res;

	// The register file is always ready; writes are only expected while idle.
	assign cfg_ready = 1'b1;

	// Colour is kept in the low bits that the frame store holds.
	assign item_in.kind   = kind;
	assign item_in.pos_x  = pos_x;
	assign item_in.pos_y  = pos_y;
	assign item_in.rect_w = rect_w;
	assign item_in.rect_h = rect_h;
	assign item_in.colour = COLOUR_BITS'(colour);

	assign done           = res.done;
	assign read_colour    = res.read_colour;
	assign pixels_written = res.pixels_written;

	// Accepted requests are sequenced here: bounds, row base multiply, then the pixel walk or the read.
	cfb_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_in  (item_in),
		.busy     (busy),
		.item_q   (item_q),
		.bnd_en   (bnd_en),
		.bnd      (bnd),
		.screen_w (screen_w),
		.mem_req  (mem_req),
		.rd_data  (rd_data),
		.res      (res)
	);

	// The clip rectangle and screen size live here; the clip is narrowed or reset in the
	// same cycle as the bounds of the request are registered.
	cfb_clip_unit u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_q),
		.bnd_en    (bnd_en),
		.bnd_q     (bnd),
		.screen_w  (screen_w)
	);

	// Row-major frame store, addressed y * screen width + x with the current width.
	cfb_frame_ram u_ram (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data)
	);

	// An accepted request always makes the engine busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted but engine not busy");

	// A result only ever comes right after the engine was busy.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result without preceding work");

	// A read reports no written pixels, and a write reports no colour.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_colour != '0) |-> (pixels_written == '0))
		else $error("result carries both a colour and a pixel count");

	// The frame store is written only while the engine is busy.
	assert property (@(posedge clk) disable iff (!arst_n) mem_req.we |-> busy)
		else $error("frame store written while idle");

endmodule

@@ rtl/core/cfb_frame_ram.sv @@
`timescale 1ns / 1ps
// Single-port frame store with a registered read port.
module cfb_frame_ram import cfb_pkg::*; (
	input  logic                   clk,
	input  mem_req_t               req,
	output logic [COLOUR_BITS-1:0] rd_data_q
);

	logic [COLOUR_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.addr];
		end
	end

endmodule

@@ rtl/core/cfb_clip_unit.sv @@
`timescale 1ns / 1ps
// Screen size registers, clip rectangle and the bounds calculation for one request.
module cfb_clip_unit import cfb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  item_t            item,
	input  logic             bnd_en,
	output bounds_t          bnd_q,
	output logic [XB_W-1:0]  screen_w
);

	logic [XB_W-1:0]           sw_q;
	logic [YB_W-1:0]           sh_q;
	logic signed [COORD_W-1:0] cl_q;
	logic signed [COORD_W-1:0] ct_q;
	logic [XB_W-1:0]           cw_q;
	logic [YB_W-1:0]           ch_q;

	logic is_read;
	logic is_fill_or_narrow;
	logic signed [EDGE_W-1:0] px_e, py_e, w_e, h_e, sw_e, sh_e;
	logic signed [EDGE_W-1:0] clo_x, chi_x, clo_y, chi_y;
	logic signed [EDGE_W-1:0] mx0, mx1, my0, my1, x0, x1, y0, y1;
	logic empty;

	assign screen_w = sw_q;

	always_comb begin
		is_read           = (item.kind == KIND_READ);
		is_fill_or_narrow = (item.kind == KIND_FILL) || (item.kind == KIND_NARROW);
		px_e = EDGE_W'(item.pos_x);
		py_e = EDGE_W'(item.pos_y);
		// A single pixel is a one by one rectangle.
		w_e  = is_fill_or_narrow ? EDGE_W'(item.rect_w) : EDGE_W'(1);
		h_e  = is_fill_or_narrow ? EDGE_W'(item.rect_h) : EDGE_W'(1);
		sw_e = EDGE_W'(sw_q);
		sh_e = EDGE_W'(sh_q);
		// Reads are bounded by the screen alone.
		clo_x = is_read ? '0 : EDGE_W'(cl_q);
		clo_y = is_read ? '0 : EDGE_W'(ct_q);
		chi_x = is_read ? sw_e : EDGE_W'(cl_q) + EDGE_W'(cw_q);
		chi_y = is_read ? sh_e : EDGE_W'(ct_q) + EDGE_W'(ch_q);
		mx0 = (px_e > clo_x) ? px_e : clo_x;
		my0 = (py_e > clo_y) ? py_e : clo_y;
		mx1 = ((px_e + w_e) < chi_x) ? (px_e + w_e) : chi_x;
		my1 = ((py_e + h_e) < chi_y) ? (py_e + h_e) : chi_y;
		x0 = (mx0 > 0) ? mx0 : '0;
		y0 = (my0 > 0) ? my0 : '0;
		x1 = (mx1 < sw_e) ? mx1 : sw_e;
		y1 = (my1 < sh_e) ? my1 : sh_e;
		empty = (x1 <= x0) || (y1 <= y0);
	end

	always_ff @(posedge clk) begin
		if (bnd_en) begin
			bnd_q.empty <= empty;
			bnd_q.x0    <= x0[XB_W-1:0];
			bnd_q.x1    <= x1[XB_W-1:0];
			bnd_q.y0    <= y0[YB_W-1:0];
			bnd_q.y1    <= y1[YB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= clamp_width(SW_REG_W'(RESET_WIDTH));
			sh_q <= clamp_height(SH_REG_W'(RESET_HEIGHT));
			cl_q <= '0;
			ct_q <= '0;
			cw_q <= clamp_width(SW_REG_W'(RESET_WIDTH));
			ch_q <= clamp_height(SH_REG_W'(RESET_HEIGHT));
		end else begin
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SCREEN_WIDTH:  sw_q <= clamp_width(cfg_data[SW_REG_W-1:0]);
					REG_SCREEN_HEIGHT: sh_q <= clamp_height(cfg_data[SH_REG_W-1:0]);
				endcase
			end
			if (bnd_en && item.kind == KIND_NARROW) begin
				// The clip only shrinks, so its size always fits the screen limits.
				cl_q <= mx0[COORD_W-1:0];
				ct_q <= my0[COORD_W-1:0];
				cw_q <= (mx1 > mx0) ? XB_W'(mx1 - mx0) : '0;
				ch_q <= (my1 > my0) ? YB_W'(my1 - my0) : '0;
			end else if (bnd_en && item.kind == KIND_RESET_CLIP) begin
				cl_q <= '0;
				ct_q <= '0;
				cw_q <= sw_q;
				ch_q <= sh_q;
			end
		end
	end

endmodule

@@ rtl/core/cfb_sequencer.sv @@
`timescale 1ns / 1ps
// Request sequencer: clearing pass, row and column walk of fills, reads and result register.
module cfb_sequencer import cfb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  item_t                  item_in,
	output logic                   busy,
	output item_t                  item_q,
	output logic                   bnd_en,
	input  bounds_t                bnd,
	input  logic [XB_W-1:0]        screen_w,
	output mem_req_t               mem_req,
	input  logic [COLOUR_BITS-1:0] rd_data,
	output result_t                res
);

	seq_state_t state_q, state_d;

	logic [ADDR_W-1:0]       clr_addr_q;
	logic [ADDR_W-1:0]       base_q;
	logic [XB_W-1:0]         x_q;
	logic [YB_W-1:0]         y_q;
	logic [COUNT_W-1:0]      count_q;
	logic [YB_W+XB_W-1:0]    prod;
	logic                    last_x, last_y;
	logic                    emit;
	logic [OUT_COLOUR_W-1:0] emit_colour;
	logic [COUNT_W-1:0]      emit_count;
	logic                    done_q;
	logic [OUT_COLOUR_W-1:0] read_colour_q;
	logic [COUNT_W-1:0]      pixels_written_q;

	assign busy   = (state_q != ST_IDLE);
	assign prod   = bnd.y0 * screen_w;
	assign last_x = (x_q + XB_W'(1)) == bnd.x1;
	assign last_y = (y_q + YB_W'(1)) == bnd.y1;

	assign res.done           = done_q;
	assign res.read_colour    = read_colour_q;
	assign res.pixels_written = pixels_written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		bnd_en      = 1'b0;
		mem_req     = '0;
		emit        = 1'b0;
		emit_colour = '0;
		emit_count  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_addr_q;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_BOUNDS;
				end
			end
			ST_BOUNDS: begin
				bnd_en = 1'b1;
				case (item_q.kind) inside
					KIND_PIXEL, KIND_FILL, KIND_READ: state_d = ST_BASE;
					default: begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_BASE: begin
				if (bnd.empty) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else if (item_q.kind == KIND_READ) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = base_q + ADDR_W'(x_q);
				mem_req.wdata = item_q.colour;
				if (last_x && last_y) begin
					emit       = 1'b1;
					emit_count = count_q + COUNT_W'(1);
					state_d    = ST_IDLE;
				end
			end
			ST_READ: begin
				mem_req.re   = 1'b1;
				mem_req.addr = base_q + ADDR_W'(x_q);
				state_d      = ST_RDOUT;
			end
			ST_RDOUT: begin
				emit        = 1'b1;
				emit_colour = OUT_COLOUR_W'(rd_data);
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			read_colour_q    <= emit_colour;
			pixels_written_q <= emit_count;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item_in;
				end
			end
			ST_BASE: begin
				base_q  <= prod[ADDR_W-1:0];
				x_q     <= bnd.x0;
				y_q     <= bnd.y0;
				count_q <= '0;
			end
			ST_FILL: begin
				count_q <= count_q + COUNT_W'(1);
				if (last_x) begin
					x_q    <= bnd.x0;
					y_q    <= y_q + YB_W'(1);
					base_q <= base_q + ADDR_W'(screen_w);
				end else begin
					x_q <= x_q + XB_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
